>>> hdl/tpi_pkg.sv
// Shared types and constants of the table permutation interleaver.
package tpi_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam int unsigned BLOCK_LEN_W = 13;
  localparam int unsigned TABLE_W     = 12;

  localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 13'd4096;

  // Register index of block_len (byte address 4*index).
  localparam logic REG_BLOCK_LEN = 1'b0;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_DRAIN = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         data_byte;
    logic [TABLE_W-1:0] table_index;
    logic [TABLE_W-1:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_block;
    logic       bad_index;
  } out_item_t;

endpackage

>>> hdl/tpi_queue.sv
// Small register FIFO between the front and back halves of the interleaver.
module tpi_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH+1);

  logic [W-1:0]       slot_r [DEPTH];
  logic [AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

>>> hdl/tpi_front.sv
// Front half: accepts items, keeps block positions and the permutation table.
module tpi_front #(
  parameter int unsigned MAX_BLOCK   = tpi_pkg::MAX_BLOCK_DEF,
  parameter int unsigned QUEUE_DEPTH = tpi_pkg::QUEUE_DEPTH,
  localparam int unsigned PW  = $clog2(MAX_BLOCK),
  localparam int unsigned LW  = $clog2(MAX_BLOCK + 1),
  localparam int unsigned EW  = 2 * PW + 14,
  localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpi_pkg::in_item_t in_data,
  input  logic [LW-1:0]     eff_len,
  input  logic [QCW-1:0]    q_count,
  output logic              q_push,
  output logic [EW-1:0]     q_wdata
);

  localparam int unsigned CW = (LW > tpi_pkg::BLOCK_LEN_W) ? LW : tpi_pkg::BLOCK_LEN_W;
  localparam int unsigned SW = (PW > tpi_pkg::TABLE_W) ? PW : tpi_pkg::TABLE_W;

  typedef struct packed {
    logic          wr_en;
    logic          wbank;
    logic [PW-1:0] wpos;
    logic [7:0]    wbyte;
    logic          emit;
    logic          rbank;
    logic [PW-1:0] src;
    logic          bad;
    logic          last;
  } entry_t;

  logic [tpi_pkg::TABLE_W-1:0] tbl_mem [MAX_BLOCK];
  logic [tpi_pkg::TABLE_W-1:0] tbl_rd_r;

  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          bank_r, bank_nxt;
  logic          pend_r, pend_nxt;

  logic          s1_v_r;
  logic          s1_wr_en_r;
  logic          s1_wbank_r;
  logic [PW-1:0] s1_wpos_r;
  logic [7:0]    s1_wbyte_r;
  logic          s1_emit_r;
  logic          s1_last_r;

  logic          acc;
  logic          is_load, is_data, is_drain;
  logic          emit_now;
  logic [PW:0]   rp_inc, wp_inc;
  logic          rd_done, wr_done;
  logic          idx_ok;
  logic [SW-1:0] idx_ext, src_ext;
  entry_t        ent;

  // A new item is taken only when the queue has room for it and the one in flight.
  assign in_ready = ({1'b0, q_count} + {{QCW{1'b0}}, s1_v_r}) < (QCW+1)'(QUEUE_DEPTH);
  assign acc      = in_valid && in_ready;

  assign is_load  = (in_data.action == tpi_pkg::ACT_LOAD);
  assign is_data  = (in_data.action == tpi_pkg::ACT_DATA);
  assign is_drain = (in_data.action == tpi_pkg::ACT_DRAIN);
  assign emit_now = (is_data || is_drain) && pend_r;

  assign rp_inc  = {1'b0, rp_r} + (PW+1)'(1);
  assign wp_inc  = {1'b0, wp_r} + (PW+1)'(1);
  assign rd_done = CW'(rp_inc) >= CW'(eff_len);
  assign wr_done = CW'(wp_inc) >= CW'(eff_len);

  assign idx_ext = SW'(in_data.table_index);
  assign idx_ok  = CW'(in_data.table_index) < CW'(MAX_BLOCK);

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    bank_nxt = bank_r;
    pend_nxt = pend_r;
    if (acc) begin
      if (emit_now) begin
        if (rd_done) begin
          rp_nxt   = '0;
          pend_nxt = 1'b0;
        end else begin
          rp_nxt = rp_inc[PW-1:0];
        end
      end
      // A block that completes becomes pending and its reading starts over.
      if (is_data) begin
        if (wr_done) begin
          wp_nxt   = '0;
          bank_nxt = ~bank_r;
          pend_nxt = 1'b1;
          rp_nxt   = '0;
        end else begin
          wp_nxt = wp_inc[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      bank_r <= 1'b0;
      pend_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      bank_r <= bank_nxt;
      pend_r <= pend_nxt;
      s1_v_r <= acc && (emit_now || is_data);
    end
  end

  always_ff @(posedge clk) begin
    s1_wr_en_r <= is_data;
    s1_wbank_r <= bank_r;
    s1_wpos_r  <= wp_r;
    s1_wbyte_r <= in_data.data_byte;
    s1_emit_r  <= emit_now;
    s1_last_r  <= rd_done;
  end

  // The table is read every cycle at the current read position; a load never
  // needs the data, so read-before-write at the same edge is harmless.
  always_ff @(posedge clk) begin
    if (acc && is_load && idx_ok) begin
      tbl_mem[idx_ext[PW-1:0]] <= in_data.table_value;
    end
    tbl_rd_r <= tbl_mem[rp_r];
  end

  assign src_ext = SW'(tbl_rd_r);

  always_comb begin
    ent.wr_en = s1_wr_en_r;
    ent.wbank = s1_wbank_r;
    ent.wpos  = s1_wpos_r;
    ent.wbyte = s1_wbyte_r;
    ent.emit  = s1_emit_r;
    ent.rbank = ~s1_wbank_r;
    ent.src   = src_ext[PW-1:0];
    ent.bad   = !(CW'(tbl_rd_r) < CW'(eff_len));
    ent.last  = s1_last_r;
  end

  assign q_push  = s1_v_r;
  assign q_wdata = ent;

endmodule

>>> hdl/tpi_back.sv
// Back half: ping-pong byte store and the registered result stage.
module tpi_back #(
  parameter int unsigned MAX_BLOCK = tpi_pkg::MAX_BLOCK_DEF,
  localparam int unsigned PW = $clog2(MAX_BLOCK),
  localparam int unsigned EW = 2 * PW + 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [EW-1:0]      q_rdata,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tpi_pkg::out_item_t out_data
);

  typedef struct packed {
    logic          wr_en;
    logic          wbank;
    logic [PW-1:0] wpos;
    logic [7:0]    wbyte;
    logic          emit;
    logic          rbank;
    logic [PW-1:0] src;
    logic          bad;
    logic          last;
  } entry_t;

  // Each half spans the full position range, so {bank, position} always fits.
  logic [7:0] store_mem [2 ** (PW + 1)];

  entry_t     head;
  logic       out_v_r, out_v_nxt;
  logic [7:0] rd_r;
  logic       last_r;
  logic       bad_r;
  logic       do_emit;

  assign head = entry_t'(q_rdata);

  // Write-only entries drain freely; an emitting entry waits for the result slot.
  assign q_pop   = !q_empty && (!head.emit || !out_v_r || out_ready);
  assign do_emit = q_pop && head.emit;

  always_comb begin
    out_v_nxt = out_v_r;
    if (do_emit) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  // Read and write halves always differ, so both ports act in the same cycle.
  always_ff @(posedge clk) begin
    if (q_pop && head.wr_en) begin
      store_mem[{head.wbank, head.wpos}] <= head.wbyte;
    end
    if (do_emit) begin
      rd_r   <= store_mem[{head.rbank, head.src}];
      last_r <= head.last;
      bad_r  <= head.bad;
    end
  end

  assign out_valid              = out_v_r;
  assign out_data.out_byte      = bad_r ? 8'h00 : rd_r;
  assign out_data.last_of_block = last_r;
  assign out_data.bad_index     = bad_r;

endmodule

>>> hdl/table_permutation_interleaver_top.sv
// Top level of the table permutation interleaver with its register port.
//
// The in_ channel takes items of three kinds: a table load writes one entry of
// the permutation table, a data item writes one byte of the current block and,
// while an earlier block is pending, yields one permuted byte of it, and a
// drain item yields one pending byte with no new input. Results leave on the
// out_ channel; last_of_block marks the final byte of a block, bad_index a
// table entry not below the block length (that byte reads as zero).
// Blocks leave one block behind the input. On the way to a valid result the
// table is read at the edge that accepts the item, the entry then goes through
// the queue, and the byte store read is registered in the result stage.
// One item per clock is taken sustained while out_ready stays high; the
// in_ready limit comes from the four-entry queue between the halves.
// When out_ready is low, items keep flowing in until the queue fills, then
// in_ready drops. Reset clears block positions and bank state and sets
// block_len to 4096; table and byte store keep no reset and must be written
// before use. block_len sits at address 0 of the APB port; write it only idle.
module table_permutation_interleaver_top #(
  parameter int unsigned MAX_BLOCK = tpi_pkg::MAX_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpi_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned PW  = $clog2(MAX_BLOCK);
  localparam int unsigned LW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned EW  = 2 * PW + 14;
  localparam int unsigned QD  = tpi_pkg::QUEUE_DEPTH;
  localparam int unsigned QCW = $clog2(QD + 1);
  localparam int unsigned BW  = tpi_pkg::BLOCK_LEN_W;
  localparam int unsigned CW  = (LW > BW) ? LW : BW;

  logic [BW-1:0]  block_len_r, block_len_nxt;
  logic [LW-1:0]  eff_len;
  logic           reg_wr;
  logic           q_push, q_pop, q_empty;
  logic [EW-1:0]  q_wdata, q_rdata;
  logic [QCW-1:0] q_count;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && (paddr[2] == tpi_pkg::REG_BLOCK_LEN);

  always_comb begin
    block_len_nxt = block_len_r;
    if (reg_wr) begin
      block_len_nxt = pwdata[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= tpi_pkg::BLOCK_LEN_RESET;
    end else begin
      block_len_r <= block_len_nxt;
    end
  end

  assign prdata = (paddr[2] == tpi_pkg::REG_BLOCK_LEN) ? 32'(block_len_r) : 32'h0;

  // Zero acts as one, and anything above the store size acts as the store size.
  always_comb begin
    if (block_len_r == '0) begin
      eff_len = LW'(1);
    end else if (CW'(block_len_r) > CW'(MAX_BLOCK)) begin
      eff_len = LW'(MAX_BLOCK);
    end else begin
      eff_len = LW'(block_len_r);
    end
  end

  tpi_front #(
    .MAX_BLOCK   (MAX_BLOCK),
    .QUEUE_DEPTH (QD)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .eff_len  (eff_len),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  tpi_queue #(
    .W     (EW),
    .DEPTH (QD)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  tpi_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb.sv
// Testbench of the table permutation interleaver: directed and random items against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXB = tpi_pkg::MAX_BLOCK_DEF;
  // Action code 3 is not defined by the block; it must be ignored.
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam bit [12:0] PHASE_LENS [14] = '{5, 1, 16, 2, 9, 0, 31, 64, 3, 12, 7, 48, 1, 20};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tpi_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  tpi_pkg::out_item_t out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  bit gapless;
  bit hold_request;

  class interleave_scoreboard;
    logic [tpi_pkg::TABLE_W-1:0]     perm_table [MAXB];
    logic [7:0]                      bank_bytes [2*MAXB];
    int unsigned                     wr_pos;
    int unsigned                     rd_pos;
    bit                              wr_bank;
    bit                              pending;
    logic [tpi_pkg::BLOCK_LEN_W-1:0] len_reg;
    tpi_pkg::out_item_t              expected_bytes [$];
    int unsigned                     errors;

    function new();
      wr_pos  = 0;
      rd_pos  = 0;
      wr_bank = 1'b0;
      pending = 1'b0;
      len_reg = tpi_pkg::BLOCK_LEN_RESET;
      errors  = 0;
    endfunction

    function int unsigned block_size();
      if (len_reg == 0) return 1;
      if (len_reg > MAXB) return MAXB;
      return len_reg;
    endfunction

    // Next byte of the pending block, read through the permutation table.
    function bit take_permuted_byte(output tpi_pkg::out_item_t r);
      int unsigned len;
      int unsigned src;
      len = block_size();
      r = '0;
      if (!pending) return 1'b0;
      src = perm_table[rd_pos];
      if (src < len) begin
        r.out_byte = bank_bytes[(wr_bank ? 0 : MAXB) + src];
      end else begin
        r.bad_index = 1'b1;
      end
      rd_pos++;
      if (rd_pos >= len) begin
        r.last_of_block = 1'b1;
        rd_pos = 0;
        pending = 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_accepted(tpi_pkg::in_item_t it);
      tpi_pkg::out_item_t r;
      case (it.action)
        tpi_pkg::ACT_LOAD: perm_table[it.table_index] = it.table_value;
        tpi_pkg::ACT_DRAIN: begin
          if (take_permuted_byte(r)) expected_bytes.push_back(r);
        end
        tpi_pkg::ACT_DATA: begin
          if (take_permuted_byte(r)) expected_bytes.push_back(r);
          bank_bytes[(wr_bank ? MAXB : 0) + wr_pos] = it.data_byte;
          wr_pos++;
          if (wr_pos >= block_size()) begin
            wr_pos  = 0;
            wr_bank = ~wr_bank;
            pending = 1'b1;
            rd_pos  = 0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(tpi_pkg::out_item_t got);
      tpi_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result item: out_byte %0h last_of_block %0b bad_index %0b",
               got.out_byte, got.last_of_block, got.bad_index);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.last_of_block !== want.last_of_block) begin
        $error("last_of_block: expected %0b, got %0b", want.last_of_block, got.last_of_block);
        errors++;
      end
      if (got.bad_index !== want.bad_index) begin
        $error("bad_index: expected %0b, got %0b", want.bad_index, got.bad_index);
        errors++;
      end
    endfunction
  endclass

  interleave_scoreboard sb = new();

  table_permutation_interleaver_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned effective_len(bit [12:0] v);
    if (v == 0) return 1;
    if (v > MAXB) return MAXB;
    return v;
  endfunction

  function automatic tpi_pkg::in_item_t mk_item(logic [1:0] act, logic [7:0] b,
                                                logic [11:0] idx, logic [11:0] val);
    tpi_pkg::in_item_t it;
    it.action      = act;
    it.data_byte   = b;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  // Table loads are aimed inside the block half the time and mostly point inside it.
  function automatic tpi_pkg::in_item_t random_item(int unsigned len);
    tpi_pkg::in_item_t it;
    int unsigned       r;
    it = mk_item(tpi_pkg::ACT_DATA, 8'($urandom), 12'($urandom), 12'($urandom));
    r = $urandom_range(0, 99);
    if (r < 74) begin
      it.action = tpi_pkg::ACT_DATA;
    end else if (r < 86) begin
      it.action = tpi_pkg::ACT_DRAIN;
    end else if (r < 95) begin
      it.action = tpi_pkg::ACT_LOAD;
      if ($urandom_range(0, 1) == 0) it.table_index = 12'($urandom_range(0, len - 1));
      if ($urandom_range(0, 3) != 0) it.table_value = 12'($urandom_range(0, len - 1));
    end else begin
      it.action = ACT_IGNORED;
    end
    return it;
  endfunction

  // The caller is at a falling edge; on return it is at the falling edge after acceptance.
  task automatic send_item(tpi_pkg::in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_accepted(it);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_block_len(bit [12:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {tpi_pkg::REG_BLOCK_LEN, 2'b00};
    pwdata  = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.len_reg = v;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic fill_table(int unsigned len);
    int unsigned val;
    for (int unsigned i = 0; i < len; i++) begin
      if (len < MAXB && $urandom_range(0, 9) == 0) val = $urandom_range(len, MAXB - 1);
      else val = $urandom_range(0, len - 1);
      send_item(mk_item(tpi_pkg::ACT_LOAD, 8'($urandom), 12'(i), 12'(val)));
    end
  endtask

  // A longer block would read bytes of the pending block that were never written,
  // so the pending block is drained before the length grows.
  task automatic run_phase(bit [12:0] len_val, bit reload, int unsigned n, bit squeeze);
    int unsigned len;
    len = effective_len(len_val);
    wait_idle();
    if (len > sb.block_size() && sb.pending) begin
      while (sb.pending) begin
        send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'($urandom), 12'($urandom), 12'($urandom)));
      end
      wait_idle();
    end
    write_block_len(len_val);
    gapless = ($urandom_range(0, 3) == 0);
    if (reload) fill_table(len);
    for (int unsigned i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) hold_request = 1'b1;
      send_item(random_item(len));
    end
  endtask

  initial begin
    int unsigned stall_left;
    int unsigned r;
    bit          hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = 200;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (!gapless) begin
          r = $urandom_range(0, 99);
          if (r < 15) stall_left = $urandom_range(1, 3);
          else if (r < 18) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    rst_n        = 1'b0;
    gapless      = 1'b0;
    hold_request = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Nothing pending yet, and an undefined action.
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(ACT_IGNORED, 8'hFF, 12'hFFF, 12'hFFF));
    wait_idle();

    // Zero length acts as one byte per block.
    write_block_len(13'd0);
    send_item(mk_item(tpi_pkg::ACT_LOAD, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'hFF, 12'hFFF, 12'hFFF));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h5A, 12'h000, 12'h000));
    // An entry past the block length reads as zero with bad_index.
    send_item(mk_item(tpi_pkg::ACT_LOAD, 8'h00, 12'h000, 12'hFFF));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h81, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    wait_idle();

    write_block_len(13'd3);
    send_item(mk_item(tpi_pkg::ACT_LOAD, 8'h00, 12'd0, 12'd2));
    send_item(mk_item(tpi_pkg::ACT_LOAD, 8'h00, 12'd1, 12'd0));
    send_item(mk_item(tpi_pkg::ACT_LOAD, 8'h00, 12'd2, 12'd1));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'hC3, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h3C, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h7E, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h01, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'h80, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DATA, 8'hFE, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));
    send_item(mk_item(tpi_pkg::ACT_DRAIN, 8'h00, 12'h000, 12'h000));

    for (int i = 0; i < 7; i++) run_phase(PHASE_LENS[i], 1'b1, 85, i == 2);

    // A length above the maximum acts as the maximum, so no block completes here;
    // the next, shorter length then ends the partly written block at once.
    run_phase(13'd8191, 1'b0, 200, 1'b0);

    for (int i = 7; i < 14; i++) run_phase(PHASE_LENS[i], 1'b1, 85, 1'b0);

    wait_idle();
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
